// ===== hw/rtl/two_register_cpu_step_macros.svh =====
// Assertion macros used by the checker file of the CPU step block.
`ifndef TWO_REGISTER_CPU_STEP_MACROS_SVH
`define TWO_REGISTER_CPU_STEP_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define HCS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define HCS_ASSERT(lbl, prop, msg) \
  `HCS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/hcs_pkg.sv =====
// Shared types, constants and ALU codes of the two-register CPU step block.
package hcs_pkg;

  localparam int RAM_WORDS = 32768;
  localparam int RAM_AW    = $clog2(RAM_WORDS);

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 88;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_ADDR = 2'd1,
    ERR_CODE = 2'd2
  } err_e;

  // ALU compute codes (zx nx zy ny f no)
  localparam logic [5:0] ALU_ZERO    = 6'b101010;
  localparam logic [5:0] ALU_ONE     = 6'b111111;
  localparam logic [5:0] ALU_NEG_ONE = 6'b111010;
  localparam logic [5:0] ALU_D       = 6'b001100;
  localparam logic [5:0] ALU_Y       = 6'b110000;
  localparam logic [5:0] ALU_NOT_D   = 6'b001101;
  localparam logic [5:0] ALU_NOT_Y   = 6'b110001;
  localparam logic [5:0] ALU_NEG_D   = 6'b001111;
  localparam logic [5:0] ALU_NEG_Y   = 6'b110011;
  localparam logic [5:0] ALU_D_INC   = 6'b011111;
  localparam logic [5:0] ALU_Y_INC   = 6'b110111;
  localparam logic [5:0] ALU_D_DEC   = 6'b001110;
  localparam logic [5:0] ALU_Y_DEC   = 6'b110010;
  localparam logic [5:0] ALU_ADD     = 6'b000010;
  localparam logic [5:0] ALU_D_SUB_Y = 6'b010011;
  localparam logic [5:0] ALU_Y_SUB_D = 6'b000111;
  localparam logic [5:0] ALU_AND     = 6'b000000;
  localparam logic [5:0] ALU_OR      = 6'b010101;

  // ALU result and code check, ALU to control
  typedef struct packed {
    logic        ok;
    logic [15:0] res;
  } alu_out_t;

  // Result item, first field in the high bits
  typedef struct packed {
    logic [5:0]  pad;
    err_e        error_code;
    logic [14:0] mem_addr;
    logic        mem_write;
    logic [15:0] alu_value;
    logic [15:0] d_value;
    logic [15:0] a_value;
    logic [15:0] next_pc;
  } result_t;

endpackage

// ===== hw/rtl/two_register_cpu_step.sv =====
// Each accepted instruction is registered into the execute stage, and its result item is
// registered into the output register when execute finishes. A new instruction is taken
// only once the one in execute has finished (updating A) before the next data RAM read of M.
// Reset: A, D and PC clear at once; then a clearing pass writes zero to all
// 32768 RAM words, one per cycle, while s_axis_tready stays low.
module two_register_cpu_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [hcs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] instr_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] next_pc, [31:16] a_value, [47:32] d_value, [63:48] alu_value,
  // [64] mem_write, [79:65] mem_addr, [81:80] error_code, [87:82] zero
  output logic [hcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int AW = hcs_pkg::RAM_AW;

  // RAM clearing pass
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // execute stage
  logic          ex_valid_q, ex_valid_d;
  logic [15:0]   ex_instr_q;
  logic          in_fire, ex_fire, out_fire;

  // architectural registers
  logic [15:0]   a_q, a_d, d_q, d_d, pc_q, pc_d;

  // output register
  logic               out_valid_q, out_valid_d;
  hcs_pkg::result_t   out_q, out_d;

  // RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata, ram_rdata;

  // decode and execute
  logic              is_c, use_m, dst_a, dst_d, dst_m, in_ram;
  logic              addr_err, commit, neg, zero, jmp;
  logic [15:0]       y_val;
  hcs_pkg::alu_out_t alu;

  assign s_axis_tready = !clr_busy_q && !ex_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign ex_fire       = ex_valid_q && (!out_valid_q || m_axis_tready);
  assign out_fire      = out_valid_q && m_axis_tready;

  assign is_c  = ex_instr_q[15];
  assign use_m = ex_instr_q[12];
  assign dst_a = ex_instr_q[5];
  assign dst_d = ex_instr_q[4];
  assign dst_m = ex_instr_q[3];

  assign in_ram = 17'(a_q) < 17'(hcs_pkg::RAM_WORDS);
  assign y_val  = use_m ? ram_rdata : a_q;

  hcs_alu u_alu (
    .code_i (ex_instr_q[11:6]),
    .d_i    (d_q),
    .y_i    (y_val),
    .alu_o  (alu)
  );

  assign addr_err = is_c && (use_m || dst_m) && !in_ram;
  assign commit   = is_c && !addr_err && alu.ok;
  assign neg      = alu.res[15];
  assign zero     = (alu.res == 16'd0);
  assign jmp      = (ex_instr_q[2] && neg) || (ex_instr_q[1] && zero) ||
                    (ex_instr_q[0] && !neg && !zero);

  // next architectural state; errors leave everything as it was
  always_comb begin
    a_d  = a_q;
    d_d  = d_q;
    pc_d = pc_q;
    if (!is_c) begin
      a_d  = {1'b0, ex_instr_q[14:0]};
      pc_d = pc_q + 16'd1;
    end else if (commit) begin
      if (dst_a) begin
        a_d = alu.res;
      end
      if (dst_d) begin
        d_d = alu.res;
      end
      // jump target is A from before the instruction
      pc_d = jmp ? a_q : pc_q + 16'd1;
    end
  end

  always_comb begin
    out_d            = '0;
    out_d.next_pc    = pc_d;
    out_d.a_value    = a_d;
    out_d.d_value    = d_d;
    out_d.error_code = hcs_pkg::ERR_OK;
    if (commit) begin
      out_d.alu_value = alu.res;
      out_d.mem_write = dst_m;
      out_d.mem_addr  = dst_m ? a_q[14:0] : 15'd0;
    end else if (addr_err) begin
      out_d.error_code = hcs_pkg::ERR_ADDR;
    end else if (is_c) begin
      out_d.error_code = hcs_pkg::ERR_CODE;
    end
  end

  // RAM access: clear sweep, then M write-back at old A
  always_comb begin
    ram_re    = in_fire;
    ram_we    = 1'b0;
    ram_waddr = a_q[AW-1:0];
    ram_wdata = alu.res;
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = 16'd0;
    end else if (ex_fire && commit && dst_m) begin
      ram_we = 1'b1;
    end
  end

  hcs_ram #(
    .WIDTH (16),
    .DEPTH (hcs_pkg::RAM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (a_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(hcs_pkg::RAM_WORDS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    ex_valid_d = ex_valid_q;
    if (in_fire) begin
      ex_valid_d = 1'b1;
    end else if (ex_fire) begin
      ex_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ex_fire) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      a_q         <= 16'd0;
      d_q         <= 16'd0;
      pc_q        <= 16'd0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      ex_valid_q  <= ex_valid_d;
      out_valid_q <= out_valid_d;
      if (ex_fire) begin
        a_q  <= a_d;
        d_q  <= d_d;
        pc_q <= pc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ex_instr_q <= s_axis_tdata;
    end
    if (ex_fire) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== hw/rtl/hcs_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module hcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hcs_alu.sv =====
// ALU of the CPU step: the 18 compute functions of D and A/M, with code check.
module hcs_alu (
  input  logic [5:0]             code_i,
  input  logic [15:0]            d_i,
  input  logic [15:0]            y_i,
  output hcs_pkg::alu_out_t      alu_o
);

  always_comb begin
    alu_o.ok  = 1'b1;
    alu_o.res = 16'd0;
    case (code_i)
      hcs_pkg::ALU_ZERO:    alu_o.res = 16'd0;
      hcs_pkg::ALU_ONE:     alu_o.res = 16'd1;
      hcs_pkg::ALU_NEG_ONE: alu_o.res = 16'hFFFF;
      hcs_pkg::ALU_D:       alu_o.res = d_i;
      hcs_pkg::ALU_Y:       alu_o.res = y_i;
      hcs_pkg::ALU_NOT_D:   alu_o.res = ~d_i;
      hcs_pkg::ALU_NOT_Y:   alu_o.res = ~y_i;
      hcs_pkg::ALU_NEG_D:   alu_o.res = 16'd0 - d_i;
      hcs_pkg::ALU_NEG_Y:   alu_o.res = 16'd0 - y_i;
      hcs_pkg::ALU_D_INC:   alu_o.res = d_i + 16'd1;
      hcs_pkg::ALU_Y_INC:   alu_o.res = y_i + 16'd1;
      hcs_pkg::ALU_D_DEC:   alu_o.res = d_i - 16'd1;
      hcs_pkg::ALU_Y_DEC:   alu_o.res = y_i - 16'd1;
      hcs_pkg::ALU_ADD:     alu_o.res = d_i + y_i;
      hcs_pkg::ALU_D_SUB_Y: alu_o.res = d_i - y_i;
      hcs_pkg::ALU_Y_SUB_D: alu_o.res = y_i - d_i;
      hcs_pkg::ALU_AND:     alu_o.res = d_i & y_i;
      hcs_pkg::ALU_OR:      alu_o.res = d_i | y_i;
      default:              alu_o.ok  = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/hcs_chk.sv =====
// Port-level checker for the CPU step block, bound to the top level.
`include "two_register_cpu_step_macros.svh"

module hcs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  `HCS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // one instruction in execute at a time
  `HCS_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item accepted during execute")

  `HCS_ASSERT(a_err_legal, m_axis_tvalid |-> (m_axis_tdata[81:80] == hcs_pkg::ERR_OK || m_axis_tdata[81:80] == hcs_pkg::ERR_ADDR || m_axis_tdata[81:80] == hcs_pkg::ERR_CODE) && m_axis_tdata[87:82] == 6'd0, "bad error code or padding")

  `HCS_ASSERT(a_err_quiet, m_axis_tvalid && m_axis_tdata[81:80] != hcs_pkg::ERR_OK |-> !m_axis_tdata[64] && m_axis_tdata[63:48] == 16'd0, "error item carries a write")

  `HCS_ASSERT(a_addr_zero, m_axis_tvalid && !m_axis_tdata[64] |-> m_axis_tdata[79:65] == 15'd0, "address set without write")

endmodule

bind two_register_cpu_step hcs_chk u_hcs_chk (.*);

// ===== test/two_register_cpu_step_tb.sv =====
// Self-checking testbench for the two-register CPU step block.
module two_register_cpu_step_tb;

  localparam int CYCLE_LIMIT = 600000;

  // destination and jump selects of a compute instruction
  localparam logic [2:0] DST_NONE = 3'b000;
  localparam logic [2:0] DST_A    = 3'b100;
  localparam logic [2:0] DST_D    = 3'b010;
  localparam logic [2:0] DST_M    = 3'b001;
  localparam logic [2:0] JMP_NONE = 3'b000;
  localparam logic [5:0] BAD_CODE = 6'b000001;

  localparam logic [5:0] VALID_CODES [18] = '{
    hcs_pkg::ALU_ZERO, hcs_pkg::ALU_ONE, hcs_pkg::ALU_NEG_ONE, hcs_pkg::ALU_D,
    hcs_pkg::ALU_Y, hcs_pkg::ALU_NOT_D, hcs_pkg::ALU_NOT_Y, hcs_pkg::ALU_NEG_D,
    hcs_pkg::ALU_NEG_Y, hcs_pkg::ALU_D_INC, hcs_pkg::ALU_Y_INC, hcs_pkg::ALU_D_DEC,
    hcs_pkg::ALU_Y_DEC, hcs_pkg::ALU_ADD, hcs_pkg::ALU_D_SUB_Y, hcs_pkg::ALU_Y_SUB_D,
    hcs_pkg::ALU_AND, hcs_pkg::ALU_OR
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] instr_word
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [15:0] next_pc, [31:16] a_value, [47:32] d_value, [63:48] alu_value,
  // [64] mem_write, [79:65] mem_addr, [81:80] error_code, [87:82] zero
  logic [87:0] m_axis_tdata;

  // CPU state as the predictor sees it
  logic [15:0] a_mdl;
  logic [15:0] d_mdl;
  logic [15:0] pc_mdl;
  logic [15:0] ram_mdl [hcs_pkg::RAM_WORDS];

  hcs_pkg::result_t pending_results [$];
  int      mismatch_count;
  int      cycle_count;
  bit      idle_en;
  int      sink_hold_cycles;

  two_register_cpu_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [15:0] alu_compute(input logic [5:0] code,
                                              input logic [15:0] x,
                                              input logic [15:0] y,
                                              output logic ok);
    logic [15:0] res;
    ok  = 1'b1;
    res = '0;
    case (code)
      hcs_pkg::ALU_ZERO:    res = 16'h0000;
      hcs_pkg::ALU_ONE:     res = 16'h0001;
      hcs_pkg::ALU_NEG_ONE: res = 16'hFFFF;
      hcs_pkg::ALU_D:       res = x;
      hcs_pkg::ALU_Y:       res = y;
      hcs_pkg::ALU_NOT_D:   res = ~x;
      hcs_pkg::ALU_NOT_Y:   res = ~y;
      hcs_pkg::ALU_NEG_D:   res = -x;
      hcs_pkg::ALU_NEG_Y:   res = -y;
      hcs_pkg::ALU_D_INC:   res = x + 16'd1;
      hcs_pkg::ALU_Y_INC:   res = y + 16'd1;
      hcs_pkg::ALU_D_DEC:   res = x - 16'd1;
      hcs_pkg::ALU_Y_DEC:   res = y - 16'd1;
      hcs_pkg::ALU_ADD:     res = x + y;
      hcs_pkg::ALU_D_SUB_Y: res = x - y;
      hcs_pkg::ALU_Y_SUB_D: res = y - x;
      hcs_pkg::ALU_AND:     res = x & y;
      hcs_pkg::ALU_OR:      res = x | y;
      default:              ok = 1'b0;
    endcase
    return res;
  endfunction

  // Executes one instruction on the predictor state, returns the result item.
  function automatic hcs_pkg::result_t cpu_execute(input logic [15:0] w);
    hcs_pkg::result_t r;
    logic [15:0] a_old;
    logic [15:0] y;
    logic [15:0] res;
    logic        ok;
    logic        jmp;
    r = '0;
    r.error_code = hcs_pkg::ERR_OK;
    if (!w[15]) begin
      a_mdl  = {1'b0, w[14:0]};
      pc_mdl = pc_mdl + 16'd1;
    end else begin
      a_old = a_mdl;
      if ((w[12] || w[3]) && a_old >= hcs_pkg::RAM_WORDS) begin
        r.error_code = hcs_pkg::ERR_ADDR;
      end else begin
        y   = w[12] ? ram_mdl[a_old[14:0]] : a_old;
        res = alu_compute(w[11:6], d_mdl, y, ok);
        if (!ok) begin
          r.error_code = hcs_pkg::ERR_CODE;
        end else begin
          jmp = (w[2] && res[15]) || (w[1] && res == 16'd0) ||
                (w[0] && !res[15] && res != 16'd0);
          r.alu_value = res;
          if (w[4]) d_mdl = res;
          if (w[5]) a_mdl = res;
          if (w[3]) begin
            ram_mdl[a_old[14:0]] = res;
            r.mem_write          = 1'b1;
            r.mem_addr           = a_old[14:0];
          end
          pc_mdl = jmp ? a_old : pc_mdl + 16'd1;
        end
      end
    end
    r.next_pc = pc_mdl;
    r.a_value = a_mdl;
    r.d_value = d_mdl;
    return r;
  endfunction

  function automatic logic [15:0] a_word(input logic [14:0] value);
    return {1'b0, value};
  endfunction

  // bits 14..13 are don't-care and get random values
  function automatic logic [15:0] c_word(input logic use_m, input logic [5:0] code,
                                         input logic [2:0] dest, input logic [2:0] jump);
    return {1'b1, 2'($urandom_range(0, 3)), use_m, code, dest, jump};
  endfunction

  function automatic logic [15:0] random_instr();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) return a_word(15'($urandom_range(0, 15)));
    if (sel < 30) return a_word(15'($urandom_range(0, 32767)));
    if (sel < 90)
      return c_word(1'($urandom_range(0, 1)), VALID_CODES[$urandom_range(0, 17)],
                    {($urandom_range(0, 4) == 0), 2'($urandom_range(0, 3))},
                    3'($urandom_range(0, 7)));
    return 16'($urandom);
  endfunction

  // Offers one item and records its expected result once accepted.
  task automatic issue_instr(input logic [15:0] w);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(cpu_execute(w));
  endtask

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk_i) begin : result_check
    hcs_pkg::result_t got;
    hcs_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = hcs_pkg::result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result item %h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.next_pc !== want.next_pc || got.a_value !== want.a_value ||
            got.d_value !== want.d_value || got.alu_value !== want.alu_value ||
            got.mem_write !== want.mem_write || got.mem_addr !== want.mem_addr ||
            got.error_code !== want.error_code || got.pad !== want.pad)
          note_failure($sformatf(
            "pc %h/%h a %h/%h d %h/%h alu %h/%h wr %b/%b addr %h/%h err %0d/%0d pad %h/%h",
            want.next_pc, got.next_pc, want.a_value, got.a_value,
            want.d_value, got.d_value, want.alu_value, got.alu_value,
            want.mem_write, got.mem_write, want.mem_addr, got.mem_addr,
            want.error_code, got.error_code, want.pad, got.pad));
      end
    end
  end

  // Output side: random stalls, or one long hold-off on request.
  initial begin : sink_ctrl
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic test_const_load();
    issue_instr(a_word(15'h0000));
    issue_instr(a_word(15'h7FFF));
  endtask

  // Every ALU code, alternating A and M operand, with a spread of jump masks.
  task automatic test_alu_codes();
    for (int i = 0; i < 18; i++)
      issue_instr(c_word(1'(i % 2), VALID_CODES[i], (i % 3 == 0) ? DST_M : DST_D,
                         3'(i % 8)));
  endtask

  task automatic test_error_cases();
    issue_instr(c_word(1'b0, hcs_pkg::ALU_NEG_ONE, DST_A, JMP_NONE));  // A beyond the RAM
    issue_instr(c_word(1'b1, hcs_pkg::ALU_D, DST_D, JMP_NONE));        // reads M
    issue_instr(c_word(1'b0, hcs_pkg::ALU_D, DST_M, JMP_NONE));        // writes M
    issue_instr(c_word(1'b1, BAD_CODE, DST_D, JMP_NONE));     // address wins
    issue_instr(c_word(1'b0, BAD_CODE, DST_NONE, JMP_NONE));  // bad code only
    issue_instr(a_word(15'd3));
  endtask

  // Output held off while items keep coming, so the input must stall.
  task automatic test_backpressure();
    idle_en          = 1'b0;
    sink_hold_cycles = 300;
    for (int i = 0; i < 40; i++) issue_instr(random_instr());
    idle_en = 1'b1;
  endtask

  task automatic test_random(input int count, input bit with_idle);
    idle_en = with_idle;
    for (int i = 0; i < count; i++) issue_instr(random_instr());
  endtask

  initial begin
    mismatch_count   = 0;
    cycle_count      = 0;
    sink_hold_cycles = 0;
    idle_en          = 1'b1;
    a_mdl            = '0;
    d_mdl            = '0;
    pc_mdl           = '0;
    foreach (ram_mdl[i]) ram_mdl[i] = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_const_load();
    test_alu_codes();
    test_error_cases();
    test_backpressure();
    test_random(1360, 1'b1);
    test_random(350, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
